[rtl/core/psr_pkg.sv]
// ----------------------------------------------------------------------------
// psr_pkg
// Shared types, constants and helpers for the palette scale/rotate renderer.
// ----------------------------------------------------------------------------
package psr_pkg;

    localparam int WIDTH       = 320;
    localparam int HEIGHT      = 200;
    localparam int FRAME_DEPTH = 64000;
    localparam int PAL_DEPTH   = 256;
    localparam int SRC_PITCH   = 320;
    localparam int LAND_W      = 480;
    localparam int LAND_H      = 300;
    localparam int PORT_W      = 300;
    localparam int PORT_H      = 480;

    localparam int DIV3_MUL    = 683;
    localparam int DIV3_SHIFT  = 11;

    localparam int FRAME_AW    = $clog2(FRAME_DEPTH);
    localparam int PAL_AW      = $clog2(PAL_DEPTH);
    localparam int SRC_W       = 18;

    typedef enum logic [1:0] {
        OP_WRITE_PAL  = 2'd0,
        OP_WRITE_GAME = 2'd1,
        OP_WRITE_OVL  = 2'd2,
        OP_READ       = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_DIRECT   = 2'd0,
        MODE_LAND     = 2'd1,
        MODE_PORT     = 2'd2,
        MODE_UNUSED   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CFG_RENDER_MODE = 2'd0,
        CFG_OVERLAY_ON  = 2'd1,
        CFG_SPARE_2     = 2'd2,
        CFG_SPARE_3     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic take;
        logic addr_en;
        logic frame_en;
        logic pal_en;
        logic out_load;
    } t_ctl;

    typedef struct packed {
        logic is_read;
        logic out_valid;
    } t_sts;

    // 1.5x axis: two source pixels per group of three, offset 0 takes the first
    function automatic logic [8:0] scale_pos(input logic [8:0] v);
        logic [19:0] p;
        logic [8:0]  q;
        logic [8:0]  rem;
        p   = 20'(v) * 20'(DIV3_MUL);
        q   = p[DIV3_SHIFT +: 9];
        rem = v - 9'(q * 9'd3);
        return {q[7:0], 1'b0} + 9'(rem != 9'd0);
    endfunction

endpackage

[rtl/core/psr_ctrl.sv]
// ----------------------------------------------------------------------------
// psr_ctrl
// Sequencer: accept; a read adds address, frame read, palette read, deliver.
// ----------------------------------------------------------------------------
module psr_ctrl
    import psr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_stall,
    input  t_sts i_sts,
    output logic o_stall,
    output t_ctl o_ctl
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ADDR  = 5'b00010,
        S_FRAME = 5'b00100,
        S_PAL   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   out_free;

    assign out_free = !i_sts.out_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.take = 1'b1;
                    if (i_sts.is_read) n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                o_ctl.addr_en = 1'b1;
                n_state       = S_FRAME;
            end
            S_FRAME: begin
                o_ctl.frame_en = 1'b1;
                n_state        = S_PAL;
            end
            S_PAL: begin
                o_ctl.pal_en = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/core/psr_datapath.sv]
// ----------------------------------------------------------------------------
// psr_datapath
// Configuration, palette and frame stores, address mapping and result register.
// ----------------------------------------------------------------------------
module psr_datapath
    import psr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctl        i_ctl,
    output t_sts        o_sts,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_write_index,
    input  logic [15:0] i_write_value,
    input  logic [8:0]  i_out_row,
    input  logic [8:0]  i_out_col,
    input  logic        i_stall,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [1:0]  i_cfg_data,
    output logic        o_valid,
    output logic [15:0] o_pixel_value,
    output logic        o_bad_coordinate
);

    logic [15:0]         palette_mem [PAL_DEPTH];
    logic [7:0]          game_mem    [FRAME_DEPTH];
    logic [15:0]         overlay_mem [FRAME_DEPTH];

    logic [1:0]          r_mode;
    logic                r_overlay;
    logic [8:0]          r_row;
    logic [8:0]          r_col;
    logic [8:0]          r_sr;
    logic [8:0]          r_sc;
    logic [FRAME_AW-1:0] r_src;
    logic                r_bad;
    logic [7:0]          r_game_q;
    logic [15:0]         r_ovl_q;
    logic [15:0]         r_pal_q;
    logic                r_out_valid;
    logic [15:0]         r_pixel;
    logic                r_bad_out;

    logic [SRC_W-1:0]    n_src;
    logic                ok;
    logic                n_bad;
    logic                idx_in_frame;

    assign o_sts.is_read    = (t_op'(i_operation) == OP_READ);
    assign o_sts.out_valid  = r_out_valid;
    assign o_valid          = r_out_valid;
    assign o_pixel_value    = r_pixel;
    assign o_bad_coordinate = r_bad_out;

    assign idx_in_frame = ({1'b0, i_write_index} < 17'(FRAME_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_DIRECT;
            r_overlay <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_RENDER_MODE: r_mode    <= i_cfg_data;
                CFG_OVERLAY_ON:  r_overlay <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_row <= i_out_row;
            r_col <= i_out_col;
            r_sr  <= scale_pos(i_out_row);
            r_sc  <= scale_pos(i_out_col);
            if (t_op'(i_operation) == OP_WRITE_PAL && i_write_index[15:PAL_AW] == '0) begin
                palette_mem[i_write_index[PAL_AW-1:0]] <= i_write_value;
            end
            if (t_op'(i_operation) == OP_WRITE_GAME && idx_in_frame) begin
                game_mem[i_write_index[FRAME_AW-1:0]] <= i_write_value[7:0];
            end
            if (t_op'(i_operation) == OP_WRITE_OVL && idx_in_frame) begin
                overlay_mem[i_write_index[FRAME_AW-1:0]] <= i_write_value;
            end
        end
        if (i_ctl.frame_en) begin
            r_game_q <= game_mem[r_src];
            r_ovl_q  <= overlay_mem[r_src];
        end
        if (i_ctl.pal_en) begin
            r_pal_q <= palette_mem[r_game_q];
        end
    end

    always_comb begin
        ok    = 1'b0;
        n_src = '0;
        case (t_mode'(r_mode))
            MODE_DIRECT: begin
                ok    = (r_row < 9'(HEIGHT)) && (r_col < 9'(WIDTH));
                n_src = SRC_W'(r_row) * SRC_W'(WIDTH) + SRC_W'(r_col);
            end
            MODE_LAND: begin
                ok    = (r_row < 9'(LAND_H)) && (r_col < 9'(LAND_W));
                n_src = SRC_W'(r_sr) * SRC_W'(SRC_PITCH) + SRC_W'(r_sc);
            end
            MODE_PORT: begin
                ok    = (r_row < 9'(PORT_H)) && (r_col < 9'(PORT_W));
                n_src = SRC_W'(r_sc) * SRC_W'(SRC_PITCH) + SRC_W'(SRC_PITCH - 1) - SRC_W'(r_sr);
            end
            default: ok = 1'b0;
        endcase
        n_bad = !ok || (n_src >= SRC_W'(FRAME_DEPTH));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.addr_en) begin
            r_src <= n_src[FRAME_AW-1:0];
            r_bad <= n_bad;
        end
        if (i_ctl.out_load) begin
            r_bad_out <= r_bad;
            if (r_bad) begin
                r_pixel <= '0;
            end else if (r_overlay) begin
                r_pixel <= r_ovl_q;
            end else begin
                r_pixel <= r_pal_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

[rtl/core/palette_scale_rotate_renderer_core.sv]
// ----------------------------------------------------------------------------
// palette_scale_rotate_renderer_core
// Palette-mapped frame renderer with 1x, 1.5x landscape and rotated 1.5x views.
//
//  channel  | direction | handshake          | beat
//  ---------+-----------+--------------------+----------------------------------
//  input    | in        | i_valid / o_stall  | operation, index, value, row, col
//  result   | out       | o_valid / i_stall  | pixel_value, bad_coordinate
//  config   | in        | i_cfg_valid/ready  | register index, data
//
//  A write beat is taken in the accept step alone; a read beat steps through
//  accept, address map, frame read, palette read and result load, in that order.
//  Reset clears the sequencer, mode, overlay and result valid; the stores are
//  undefined until written.
//  A stalled result holds in the output register; the next beat is accepted
//  while it waits, and a read result loads once that register frees.
// ----------------------------------------------------------------------------
module palette_scale_rotate_renderer_core
    import psr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_write_index,
    input  logic [15:0] i_write_value,
    input  logic [8:0]  i_out_row,
    input  logic [8:0]  i_out_col,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_pixel_value,
    output logic        o_bad_coordinate,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [1:0]  i_cfg_data
);

    t_ctl ctl;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    psr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_stall (o_stall),
        .o_ctl   (ctl)
    );

    psr_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .o_sts            (sts),
        .i_operation      (i_operation),
        .i_write_index    (i_write_index),
        .i_write_value    (i_write_value),
        .i_out_row        (i_out_row),
        .i_out_col        (i_out_col),
        .i_stall          (i_stall),
        .i_cfg_valid      (i_cfg_valid & o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .o_pixel_value    (o_pixel_value),
        .o_bad_coordinate (o_bad_coordinate)
    );

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.out_load |=> o_valid)
        else $error("result load did not raise valid");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.out_load |-> (!o_valid || !i_stall))
        else $error("result load overwrote a stalled beat");

    a_read_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.take && sts.is_read) |=> o_stall)
        else $error("input not held off during read");

    a_take_only_when_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.take |-> (i_valid && !o_stall))
        else $error("item taken outside handshake");

endmodule
